// ===== sv/tfp_pkg.sv =====
package tfp_pkg;

  localparam int unsigned MaxFrameLenDefault = 64;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ByteIdxW  = 6;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [CfgIndexW-1:0] CfgFirstHeader  = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgSecondHeader = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgTail         = 2'd2;

  localparam logic [ByteW-1:0] FirstHeaderReset  = 8'hAA;
  localparam logic [ByteW-1:0] SecondHeaderReset = 8'h55;
  localparam logic [ByteW-1:0] TailReset         = 8'hDD;
  localparam logic [ByteW-1:0] MinFrameLen       = 8'd2;

  typedef enum logic [2:0] {
    ST_HEAD0,
    ST_HEAD1,
    ST_LEN,
    ST_CMD,
    ST_PAYLOAD,
    ST_CK,
    ST_TAIL
  } parse_state_e;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

endpackage

// ===== sv/tlv_frame_parser_core.sv =====
// Byte-stream deframer: hunts for two header bytes, takes a length byte (2 to
// MaxFrameLen-4), stores command plus payload, checks an 8-bit additive checksum
// and a tail byte, then delivers command and payload one byte per transfer with
// index and last flags. Input takes one byte per cycle; it stalls only at a
// command or payload byte while both frame banks hold frames not yet read out.
// Output runs one byte per cycle once a frame is queued, unless out_ready_i
// stalls it; each byte passes the buffer read register and then the output
// register. Buffer contents need no clearing after reset.
module tlv_frame_parser_core #(
  parameter int unsigned MaxFrameLen = tfp_pkg::MaxFrameLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tfp_pkg::ByteW-1:0]     in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tfp_pkg::ByteW-1:0]     out_byte_o,
  output logic                          is_command_o,
  output logic [tfp_pkg::ByteIdxW-1:0]  byte_index_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tfp_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tfp_pkg::ByteW-1:0]     cfg_data_i
);

  localparam int unsigned StoreDepth = MaxFrameLen - 4;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned LenW       = $clog2(StoreDepth + 1);

  logic                      wr_en;
  logic [IdxW:0]             wr_addr;
  logic [tfp_pkg::ByteW-1:0] wr_data;
  logic                      rd_en;
  logic [IdxW:0]             rd_addr;
  logic [tfp_pkg::ByteW-1:0] rd_data;
  logic                      push;
  logic                      push_bank;
  logic [LenW-1:0]           push_len;
  logic                      pop;
  logic                      head_valid;
  logic [LenW:0]             head_data;
  tfp_pkg::bank_release_t    bank_release;

  tfp_front #(
    .MaxFrameLen(MaxFrameLen)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .push_bank_o (push_bank),
    .push_len_o  (push_len),
    .release_i   (bank_release)
  );

  tfp_desc_fifo #(
    .DataW(LenW + 1)
  ) u_desc_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  ({push_bank, push_len}),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  tfp_frame_buf #(
    .AddrW(IdxW + 1)
  ) u_frame_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  tfp_back #(
    .MaxFrameLen(MaxFrameLen)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_bank_i  (head_data[LenW]),
    .head_len_i   (head_data[LenW-1:0]),
    .pop_o        (pop),
    .release_o    (bank_release),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .is_command_o (is_command_o),
    .byte_index_o (byte_index_o),
    .last_o       (last_o)
  );

endmodule

// ===== sv/tfp_frame_buf.sv =====
module tfp_frame_buf #(
  parameter int unsigned AddrW = 7
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [tfp_pkg::ByteW-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [tfp_pkg::ByteW-1:0] rd_data_o
);

  logic [tfp_pkg::ByteW-1:0] mem [2**AddrW];
  logic [tfp_pkg::ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/tfp_desc_fifo.sv =====
module tfp_desc_fifo #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [DataW-1:0] head_data_o
);

  logic [DataW-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_pop;

  assign do_pop       = pop_i && (count_q != 2'd0);
  assign head_valid_o = (count_q != 2'd0);
  assign head_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("descriptor queue overflow");

endmodule

// ===== sv/tfp_front.sv =====
module tfp_front #(
  parameter int unsigned MaxFrameLen = tfp_pkg::MaxFrameLenDefault,
  localparam int unsigned StoreDepth = MaxFrameLen - 4,
  localparam int unsigned IdxW       = $clog2(StoreDepth),
  localparam int unsigned LenW       = $clog2(StoreDepth + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tfp_pkg::ByteW-1:0]     in_byte_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tfp_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tfp_pkg::ByteW-1:0]     cfg_data_i,
  output logic                          wr_en_o,
  output logic [IdxW:0]                 wr_addr_o,
  output logic [tfp_pkg::ByteW-1:0]     wr_data_o,
  output logic                          push_o,
  output logic                          push_bank_o,
  output logic [LenW-1:0]               push_len_o,
  input  tfp_pkg::bank_release_t        release_i
);

  tfp_pkg::parse_state_e     state_q, state_d;
  logic [tfp_pkg::ByteW-1:0] hdr0_q, hdr1_q, tail_q;
  logic [LenW-1:0]           len_q, len_d;
  logic [LenW-1:0]           fill_q, fill_d;
  logic [tfp_pkg::ByteW-1:0] sum_q, sum_d;
  logic                      wr_bank_q, wr_bank_d;
  logic [1:0]                busy_q, busy_d;
  logic                      storing;
  logic                      accept;
  logic [LenW-1:0]           fill_inc;

  assign storing     = (state_q == tfp_pkg::ST_CMD) || (state_q == tfp_pkg::ST_PAYLOAD);
  assign in_ready_o  = !(storing && busy_q[wr_bank_q]);
  assign accept      = in_valid_i && in_ready_o;
  assign fill_inc    = fill_q + LenW'(1);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    fill_d  = fill_q;
    sum_d   = sum_q;
    if (accept) begin
      unique case (state_q)
        tfp_pkg::ST_HEAD0: begin
          if (in_byte_i == hdr0_q) begin
            state_d = tfp_pkg::ST_HEAD1;
          end
        end
        tfp_pkg::ST_HEAD1: begin
          state_d = (in_byte_i == hdr1_q) ? tfp_pkg::ST_LEN : tfp_pkg::ST_HEAD0;
        end
        tfp_pkg::ST_LEN: begin
          if (in_byte_i >= tfp_pkg::MinFrameLen &&
              in_byte_i <= tfp_pkg::ByteW'(StoreDepth)) begin
            len_d   = LenW'(in_byte_i);
            fill_d  = '0;
            sum_d   = in_byte_i;
            state_d = tfp_pkg::ST_CMD;
          end else begin
            state_d = tfp_pkg::ST_HEAD0;
          end
        end
        tfp_pkg::ST_CMD: begin
          fill_d  = fill_inc;
          sum_d   = sum_q + in_byte_i;
          state_d = (len_q > LenW'(1)) ? tfp_pkg::ST_PAYLOAD : tfp_pkg::ST_CK;
        end
        tfp_pkg::ST_PAYLOAD: begin
          fill_d = fill_inc;
          sum_d  = sum_q + in_byte_i;
          if (fill_inc >= len_q) begin
            state_d = tfp_pkg::ST_CK;
          end
        end
        tfp_pkg::ST_CK: begin
          state_d = (in_byte_i == sum_q) ? tfp_pkg::ST_TAIL : tfp_pkg::ST_HEAD0;
        end
        tfp_pkg::ST_TAIL: begin
          state_d = tfp_pkg::ST_HEAD0;
        end
        default: begin
          state_d = tfp_pkg::ST_HEAD0;
        end
      endcase
    end
  end

  always_comb begin
    wr_en_o     = accept && storing;
    wr_addr_o   = {wr_bank_q, fill_q[IdxW-1:0]};
    wr_data_o   = in_byte_i;
    push_o      = accept && (state_q == tfp_pkg::ST_TAIL) && (in_byte_i == tail_q);
    push_bank_o = wr_bank_q;
    push_len_o  = len_q;
    wr_bank_d   = push_o ? ~wr_bank_q : wr_bank_q;
    busy_d      = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (push_o) begin
      busy_d[wr_bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tfp_pkg::ST_HEAD0;
      len_q     <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
      wr_bank_q <= 1'b0;
      busy_q    <= '0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      fill_q    <= fill_d;
      sum_q     <= sum_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q <= tfp_pkg::FirstHeaderReset;
      hdr1_q <= tfp_pkg::SecondHeaderReset;
      tail_q <= tfp_pkg::TailReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tfp_pkg::CfgFirstHeader:  hdr0_q <= cfg_data_i;
        tfp_pkg::CfgSecondHeader: hdr1_q <= cfg_data_i;
        tfp_pkg::CfgTail:         tail_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> storing)
    else $error("input stalled outside of a store state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_i.valid |-> busy_q[release_i.bank])
    else $error("release of a bank that holds no frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> !busy_q[wr_bank_q])
    else $error("write into a bank still awaiting delivery");

endmodule

// ===== sv/tfp_back.sv =====
module tfp_back #(
  parameter int unsigned MaxFrameLen = tfp_pkg::MaxFrameLenDefault,
  localparam int unsigned StoreDepth = MaxFrameLen - 4,
  localparam int unsigned IdxW       = $clog2(StoreDepth),
  localparam int unsigned LenW       = $clog2(StoreDepth + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  logic                         head_bank_i,
  input  logic [LenW-1:0]              head_len_i,
  output logic                         pop_o,
  output tfp_pkg::bank_release_t       release_o,
  output logic                         rd_en_o,
  output logic [IdxW:0]                rd_addr_o,
  input  logic [tfp_pkg::ByteW-1:0]    rd_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tfp_pkg::ByteW-1:0]    out_byte_o,
  output logic                         is_command_o,
  output logic [tfp_pkg::ByteIdxW-1:0] byte_index_o,
  output logic                         last_o
);

  logic [IdxW-1:0]              k_q, k_d;
  logic                         p_valid_q, p_valid_d;
  logic [IdxW-1:0]              p_idx_q;
  logic                         p_last_q;
  logic                         out_valid_q, out_valid_d;
  logic [tfp_pkg::ByteW-1:0]    out_byte_q;
  logic                         is_cmd_q;
  logic [tfp_pkg::ByteIdxW-1:0] byte_idx_q;
  logic                         last_q;
  logic                         out_free;
  logic                         p_move;
  logic                         issue;
  logic                         last_k;

  assign out_free  = !out_valid_q || out_ready_i;
  assign p_move    = p_valid_q && out_free;
  assign issue     = head_valid_i && (!p_valid_q || p_move);
  assign last_k    = (LenW'(k_q) + LenW'(1)) == head_len_i;

  assign rd_en_o         = issue;
  assign rd_addr_o       = {head_bank_i, k_q};
  assign pop_o           = issue && last_k;
  assign release_o.valid = pop_o;
  assign release_o.bank  = head_bank_i;

  always_comb begin
    k_d = k_q;
    if (issue) begin
      k_d = last_k ? '0 : k_q + IdxW'(1);
    end
    p_valid_d   = issue || (p_valid_q && !p_move);
    out_valid_d = p_move || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_idx_q  <= k_q;
      p_last_q <= last_k;
    end
    if (p_move) begin
      out_byte_q <= rd_data_i;
      is_cmd_q   <= (p_idx_q == '0);
      byte_idx_q <= tfp_pkg::ByteIdxW'(p_idx_q);
      last_q     <= p_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_command_o = is_cmd_q;
  assign byte_index_o = byte_idx_q;
  assign last_o       = last_q;

endmodule
